// ===== rtl/core/bilinear_position_weight_generator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear position weight generator
// Each macro expands to a labeled concurrent assertion, or to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_POSITION_WEIGHT_GENERATOR_ASSERT_SVH
`define BILINEAR_POSITION_WEIGHT_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BPWG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define BPWG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPWG_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define BPWG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/bpwg_pkg.sv =====
// ----------------------------------------------------------------------------
// bpwg_pkg
// Types and constants shared by the position weight generator modules.
// ----------------------------------------------------------------------------
package bpwg_pkg;

  localparam int POS_W      = 10;
  localparam int IDX_W      = 12;
  localparam int WGT_W      = 17;
  localparam int FRAC_W     = 16;
  localparam int INT_W      = 6;
  localparam int NUM_W      = 16;
  localparam int DEN_W      = 10;
  localparam int Q_W        = NUM_W - DEN_W + FRAC_W;
  localparam int BLK_W      = 9;
  localparam int FRM_W      = 8;
  localparam int SIDE_CFG_W = 11;
  localparam int FRM_CFG_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int OUT_W      = 136;

  localparam logic [INT_W-1:0] POS_LAST = INT_W'(47);
  localparam logic [IDX_W-1:0] POS_SIDE = IDX_W'(48);
  localparam logic [WGT_W-1:0] ONE_Q16  = WGT_W'(65536);

  localparam logic [SIDE_CFG_W-1:0] MIN_SIDE   = SIDE_CFG_W'(2);
  localparam logic [SIDE_CFG_W-1:0] MAX_SIDE   = SIDE_CFG_W'(1024);
  localparam logic [FRM_CFG_W-1:0]  MIN_FRAMES = FRM_CFG_W'(1);
  localparam logic [FRM_CFG_W-1:0]  MAX_FRAMES = FRM_CFG_W'(256);

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd2;

  localparam logic [1:0] W_TL = 2'd0;
  localparam logic [1:0] W_TR = 2'd1;
  localparam logic [1:0] W_BL = 2'd2;
  localparam logic [1:0] W_BR = 2'd3;

  typedef struct packed {
    logic       start;
    logic       div_step;
    logic       mul_step;
    logic [1:0] mul_sel;
    logic       load_out;
  } bpwg_cmd_t;

  typedef struct packed {
    logic out_busy;
  } bpwg_sts_t;

endpackage

// ===== rtl/core/bpwg_div.sv =====
// ----------------------------------------------------------------------------
// bpwg_div
// Restoring divider, one quotient bit per step: (num << 16) / den.
// ----------------------------------------------------------------------------
module bpwg_div (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [bpwg_pkg::NUM_W-1:0] num,
  input  logic [bpwg_pkg::DEN_W-1:0] den,
  output logic [bpwg_pkg::Q_W-1:0]   quo
);
  import bpwg_pkg::*;

  logic [DEN_W-1:0] rem;
  logic [Q_W-1:0]   sh;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem, sh[Q_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};
  assign quo   = sh;

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= num[NUM_W-1:NUM_W-DEN_W];
      sh  <= {num[NUM_W-DEN_W-1:0], FRAC_W'(0)};
    end else if (step) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh  <= {sh[Q_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/bpwg_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpwg_ctrl
// Sequencer: accept, divide, four weight multiplies, hand off to output.
// ----------------------------------------------------------------------------
`include "bilinear_position_weight_generator_assert.svh"
module bpwg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  bpwg_pkg::bpwg_sts_t  sts,
  output bpwg_pkg::bpwg_cmd_t  cmd
);
  import bpwg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int CNT_W = $clog2(Q_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(Q_W - 1);

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] div_cnt;
  logic [1:0]       mul_cnt;

  assign s_tready     = state == S_IDLE;
  assign cmd.start    = s_tvalid && s_tready;
  assign cmd.div_step = state == S_DIV;
  assign cmd.mul_step = state == S_MUL;
  assign cmd.mul_sel  = mul_cnt;
  assign cmd.load_out = (state == S_DONE) && !sts.out_busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.start) state_next = S_DIV;
      S_DIV:  if (div_cnt == DIV_LAST) state_next = S_MUL;
      S_MUL:  if (mul_cnt == W_BR) state_next = S_DONE;
      S_DONE: if (cmd.load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
      mul_cnt <= W_TL;
    end else begin
      state <= state_next;
      if (cmd.start) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (cmd.start) begin
        mul_cnt <= W_TL;
      end else if (cmd.mul_step) begin
        mul_cnt <= mul_cnt + 1'b1;
      end
    end
  end

  `BPWG_ASSERT_NEXT(a_start_div, clk, rst, cmd.start, (state == S_DIV) && (div_cnt == '0), "divide does not start clean")
  `BPWG_ASSERT_NEXT(a_div_len, clk, rst, (state == S_DIV) && (div_cnt == DIV_LAST), (state == S_MUL) && (mul_cnt == W_TL), "divide length wrong")
  `BPWG_ASSERT_NEXT(a_mul_len, clk, rst, (state == S_MUL) && (mul_cnt == W_BR), state == S_DONE, "multiply sequence overrun")

endmodule

// ===== rtl/core/bpwg_datapath.sv =====
// ----------------------------------------------------------------------------
// bpwg_datapath
// Config registers, patch walk counters, coordinate dividers, weight
// multiplier and output register.
// ----------------------------------------------------------------------------
`include "bilinear_position_weight_generator_assert.svh"
module bpwg_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bpwg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpwg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            restart,
  input  bpwg_pkg::bpwg_cmd_t             cmd,
  output bpwg_pkg::bpwg_sts_t             sts,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bpwg_pkg::OUT_W-1:0]      m_tdata,
  output logic                            m_tlast,
  output logic                            m_tuser
);
  import bpwg_pkg::*;

  function automatic logic [SIDE_CFG_W-1:0] eff_side(input logic [SIDE_CFG_W-1:0] v);
    logic [SIDE_CFG_W-1:0] c;
    c = v;
    if (v < MIN_SIDE) c = MIN_SIDE;
    else if (v > MAX_SIDE) c = MAX_SIDE;
    c[0] = 1'b0;
    return c;
  endfunction

  function automatic logic [FRM_CFG_W-1:0] eff_frames(input logic [FRM_CFG_W-1:0] v);
    logic [FRM_CFG_W-1:0] c;
    c = v;
    if (v < MIN_FRAMES) c = MIN_FRAMES;
    else if (v > MAX_FRAMES) c = MAX_FRAMES;
    return c;
  endfunction

  logic [SIDE_CFG_W-1:0] h_eff, w_eff;
  logic [FRM_CFG_W-1:0]  t_eff;
  logic [DEN_W-1:0]      den_h, den_w;
  logic [BLK_W-1:0]      h_blk_last, w_blk_last;
  logic [FRM_W-1:0]      t_last;
  logic                  cfg_hit;

  logic [BLK_W-1:0] brc, bcc, cur_brc, cur_bcc, brc_next, bcc_next;
  logic             irb, icb, cur_irb, cur_icb, irb_next, icb_next;
  logic [FRM_W-1:0] fc, cur_fc, fc_next;
  logic [POS_W-1:0] y_cur, x_cur;
  logic             fend_cur, iend_cur, blk_wrap, row_wrap, frm_wrap;
  logic [NUM_W-1:0] num_y, num_x;

  logic [POS_W-1:0] row_r, col_r;
  logic             fend_r, iend_r;
  logic [Q_W-1:0]   quo_y, quo_x;
  logic [WGT_W-1:0] fy, fx, mul_a, mul_b;
  logic [2*WGT_W-1:0] prod;
  logic [WGT_W-1:0] wgt [4];

  logic [INT_W-1:0] y0, x0, y1, x1;
  logic [IDX_W-1:0] base0, base1;

  assign den_h      = DEN_W'(h_eff - 1'b1);
  assign den_w      = DEN_W'(w_eff - 1'b1);
  assign h_blk_last = BLK_W'((h_eff >> 1) - 1'b1);
  assign w_blk_last = BLK_W'((w_eff >> 1) - 1'b1);
  assign t_last     = FRM_W'(t_eff - 1'b1);
  assign cfg_hit    = cfg_we && ((cfg_index == CFG_GRID_HEIGHT) ||
                                 (cfg_index == CFG_GRID_WIDTH) ||
                                 (cfg_index == CFG_FRAME_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      h_eff <= MIN_SIDE;
      w_eff <= MIN_SIDE;
      t_eff <= MIN_FRAMES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_HEIGHT: h_eff <= eff_side(cfg_data);
        CFG_GRID_WIDTH:  w_eff <= eff_side(cfg_data);
        CFG_FRAME_COUNT: t_eff <= eff_frames(cfg_data[FRM_CFG_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_brc  = restart ? '0 : brc;
    cur_bcc  = restart ? '0 : bcc;
    cur_irb  = restart ? 1'b0 : irb;
    cur_icb  = restart ? 1'b0 : icb;
    cur_fc   = restart ? '0 : fc;
    y_cur    = {cur_brc, cur_irb};
    x_cur    = {cur_bcc, cur_icb};
    fend_cur = (cur_brc == h_blk_last) && (cur_bcc == w_blk_last) && cur_irb && cur_icb;
    iend_cur = fend_cur && (cur_fc == t_last);
    blk_wrap = cur_irb && cur_icb;
    row_wrap = blk_wrap && (cur_bcc == w_blk_last);
    frm_wrap = row_wrap && (cur_brc == h_blk_last);
    icb_next = ~cur_icb;
    irb_next = cur_icb ? ~cur_irb : cur_irb;
    bcc_next = blk_wrap ? (row_wrap ? '0 : cur_bcc + 1'b1) : cur_bcc;
    brc_next = row_wrap ? (frm_wrap ? '0 : cur_brc + 1'b1) : cur_brc;
    fc_next  = frm_wrap ? ((cur_fc == t_last) ? '0 : cur_fc + 1'b1) : cur_fc;
    num_y    = NUM_W'(y_cur) * NUM_W'(POS_LAST);
    num_x    = NUM_W'(x_cur) * NUM_W'(POS_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      brc <= '0;
      bcc <= '0;
      irb <= 1'b0;
      icb <= 1'b0;
      fc  <= '0;
    end else if (cmd.start) begin
      brc <= brc_next;
      bcc <= bcc_next;
      irb <= irb_next;
      icb <= icb_next;
      fc  <= fc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r  <= y_cur;
      col_r  <= x_cur;
      fend_r <= fend_cur;
      iend_r <= iend_cur;
    end
  end

  bpwg_div u_div_y (
    .clk  (clk),
    .load (cmd.start),
    .step (cmd.div_step),
    .num  (num_y),
    .den  (den_h),
    .quo  (quo_y)
  );

  bpwg_div u_div_x (
    .clk  (clk),
    .load (cmd.start),
    .step (cmd.div_step),
    .num  (num_x),
    .den  (den_w),
    .quo  (quo_x)
  );

  assign fy    = {1'b0, quo_y[FRAC_W-1:0]};
  assign fx    = {1'b0, quo_x[FRAC_W-1:0]};
  assign mul_a = ((cmd.mul_sel == W_BL) || (cmd.mul_sel == W_BR)) ? fy : ONE_Q16 - fy;
  assign mul_b = ((cmd.mul_sel == W_TR) || (cmd.mul_sel == W_BR)) ? fx : ONE_Q16 - fx;
  assign prod  = (2*WGT_W)'(mul_a) * (2*WGT_W)'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      wgt[cmd.mul_sel] <= prod[FRAC_W+WGT_W-1:FRAC_W];
    end
  end

  assign y0    = quo_y[Q_W-1:FRAC_W];
  assign x0    = quo_x[Q_W-1:FRAC_W];
  assign y1    = (y0 == POS_LAST) ? y0 : y0 + 1'b1;
  assign x1    = (x0 == POS_LAST) ? x0 : x0 + 1'b1;
  assign base0 = IDX_W'(y0) * POS_SIDE;
  assign base1 = IDX_W'(y1) * POS_SIDE;

  assign sts.out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {wgt[W_BR], wgt[W_BL], wgt[W_TR], wgt[W_TL],
                  base1 + IDX_W'(x1), base1 + IDX_W'(x0),
                  base0 + IDX_W'(x1), base0 + IDX_W'(x0),
                  col_r, row_r};
      m_tlast <= iend_r;
      m_tuser <= fend_r;
    end
  end

  `BPWG_ASSERT_SAME(a_int_range, clk, rst, cmd.load_out, (y0 <= POS_LAST) && (x0 <= POS_LAST), "mapped coordinate beyond table")
  `BPWG_ASSERT_SAME(a_weight_sum, clk, rst, cmd.load_out, ((19'(wgt[0]) + 19'(wgt[1]) + 19'(wgt[2]) + 19'(wgt[3])) >= 19'd65533) && ((19'(wgt[0]) + 19'(wgt[1]) + 19'(wgt[2]) + 19'(wgt[3])) <= 19'd65536), "weights do not sum to one")
  `BPWG_ASSERT_SAME(a_item_end, clk, rst, m_tvalid && m_tlast, m_tuser, "item end without frame end")

endmodule

// ===== rtl/core/bilinear_position_weight_generator.sv =====
// ----------------------------------------------------------------------------
// bilinear_position_weight_generator
// Each item goes through 22 divider steps, four weight multiplies on one shared
// multiplier and a hand-off to the output register, which waits on output stalls.
// Bit-serial coordinate divider; a new item is accepted only after hand-off.
// Reset clears the walk to the first patch and loads 2 x 2 x 1 grid config.
// ----------------------------------------------------------------------------
module bilinear_position_weight_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bpwg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpwg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // restart
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // row, col, index_top_left, index_top_right, index_bottom_left,
  // index_bottom_right, weight_top_left, weight_top_right,
  // weight_bottom_left, weight_bottom_right
  output logic [bpwg_pkg::OUT_W-1:0]      m_tdata,
  output logic                            m_tlast,   // item_end
  output logic                            m_tuser    // frame_end
);
  import bpwg_pkg::*;

  bpwg_cmd_t cmd;
  bpwg_sts_t sts;

  bpwg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpwg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (s_tdata[0]),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
